@@ hw/rtl/psva_pkg.sv @@
// ----------------------------------------------------------------------------
// psva_pkg
// shared types, codes and constants of the pair solvation volume accumulator
// ----------------------------------------------------------------------------
package psva_pkg;

  // item action codes
  typedef enum logic [1:0] {
    ACT_LOAD_ATOM  = 2'd0,
    ACT_LOAD_CLASS = 2'd1,
    ACT_PAIR       = 2'd2,
    ACT_READ       = 2'd3
  } action_t;

  // per-atom record as kept in the atom memory
  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [7:0]  kind;
    logic        hyd;
    logic [9:0]  partner;
  } atom_word_t;

  // per-class record as kept in the class memory
  typedef struct packed {
    logic [15:0] radius;
    logic [19:0] volume;
    logic [15:0] thickness;
  } kind_word_t;

  localparam int unsigned ATOM_W = $bits(atom_word_t);
  localparam int unsigned KIND_W = $bits(kind_word_t);

  // 2/(4*pi*sqrt(pi)) in q32
  localparam logic [28:0] K_Q32   = 29'd385660408;
  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // exp(-x) with x in q12, one factor per exponent bit
  localparam int unsigned EXP_BITS = 17;
  localparam logic [31:0] EXP_T0   = 32'd2146959424;

  typedef logic [EXP_BITS-1:0][31:0] exp_tab_t;

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    t = 64'(EXP_T0);
    for (int k = 0; k < EXP_BITS; k++) begin
      tab[k] = t[31:0];
      t = (t * t + 64'h4000_0000) >> 31;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

@@ hw/rtl/psva_ram.sv @@
// ----------------------------------------------------------------------------
// psva_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module psva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pair_solvation_volume_accumulator_core.sv @@
// load atom and load class items are taken back to back, from the idle state
// read item: via S_R1 and S_R2 to the output register, waiting while a result is stalled there
// pair item: idle again after the cutoff compare if beyond cutoff, else the square
//   root, then per side the shared 64-step divider twice if thickness and r2 != 0
// reset: synchronous; afterwards the accumulator memory is cleared one entry a
//   cycle, ATOM_DEPTH entries (1024 by default), before the first item is taken
// ----------------------------------------------------------------------------
// pair_solvation_volume_accumulator_core
// per-atom gaussian shell solvation volume accumulator over pair items
// ----------------------------------------------------------------------------
module pair_solvation_volume_accumulator_core #(
  parameter int ATOM_DEPTH = 1024,
  parameter int KIND_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cutoff_we,
  input  logic [29:0] cutoff_squared,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [9:0]  atom_index,
  input  logic [9:0]  partner_index,
  input  logic [7:0]  class_index,
  input  logic signed [23:0] coord_x,
  input  logic signed [23:0] coord_y,
  input  logic signed [23:0] coord_z,
  input  logic        is_hydrogen,
  input  logic [15:0] radius_value,
  input  logic [19:0] volume_value,
  input  logic [15:0] thickness_value,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  read_atom,
  output logic [16:0] frac_volume
);
  import psva_pkg::*;

  localparam int AW = $clog2(ATOM_DEPTH);
  localparam int KW = (KIND_DEPTH > 1) ? $clog2(KIND_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_R1, S_R2,
    S_PA, S_PB, S_SQ, S_SUM, S_CMP, S_SQRT,
    S_SIDE, S_XDIV, S_EXP, S_MUL1, S_MUL2, S_VDIV,
    S_ACC_RD, S_ACC_WR
  } state_t;

  state_t state;

  // configuration register
  logic [29:0] cutoff;

  // item context
  logic [9:0]  ai_q, pj_q;
  logic        read_ok, tgt_ok;
  atom_word_t  atom_i;
  logic [7:0]  kj_idx;
  logic        ki_ok, kj_ok;
  kind_word_t  kind_i, kind_j;

  // geometry
  logic [23:0] dx, dy, dz;
  logic [47:0] sq_x, sq_y, sq_z;
  logic [49:0] r2;

  // square root, two radicand bits per step
  logic [29:0] sq_val;
  logic [16:0] sq_rem;
  logic [14:0] root;
  logic [3:0]  sq_cnt;

  // shared restoring divider, one quotient bit per step
  logic [63:0] div_num;
  logic [56:0] div_rem, div_den;
  logic [63:0] div_q;
  logic [5:0]  div_cnt;

  // exponential and scaling
  logic [16:0] exp_x;
  logic [31:0] exp_e;
  logic [4:0]  exp_k;
  logic [51:0] prod_ve;
  logic [45:0] den_v;
  logic [31:0] dv;
  logic        side;

  // accumulator clearing sweep
  logic [AW-1:0] clr_addr;

  // memory ports
  logic              a_we, a_re;
  logic [AW-1:0]     a_waddr, a_raddr;
  atom_word_t        a_wdata, a_rdata;
  logic              k_we, k_re;
  logic [KW-1:0]     k_waddr, k_raddr;
  kind_word_t        k_wdata, k_rdata;
  logic              acc_we, acc_re;
  logic [AW-1:0]     acc_waddr, acc_raddr;
  logic [31:0]       acc_wdata, acc_rdata;

  // handshake
  logic accept, out_free;
  logic ai_in, pj_in, ci_in;

  // combinational helpers
  logic [9:0]  tgt_idx;
  logic        tgt_in;
  logic        ki_in, kj_in;
  logic [18:0] sq_rem_sh;
  logic [18:0] sq_trial;
  logic        sq_bit;
  logic [57:0] div_rem_sh;
  logic [57:0] div_den_ext;
  logic        div_bit;
  logic [56:0] div_rem_new;
  logic [63:0] div_q_next;
  logic [15:0] cur_rad, cur_th;
  logic [19:0] cur_vol;
  logic [15:0] root_ext;
  logic [15:0] a_dist;
  logic [31:0] aa, tt;
  logic [63:0] exp_prod;
  logic [63:0] exp_rnd;
  logic [32:0] acc_sum;
  logic [9:0]  acc_tgt;
  logic [24:0] dxs, dys, dzs;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign ai_in = (32'(atom_index) < ATOM_DEPTH);
  assign pj_in = (32'(partner_index) < ATOM_DEPTH);
  assign ci_in = (32'(class_index) < KIND_DEPTH);

  // hydrogen reads follow the bond one level only
  assign tgt_idx = a_rdata.hyd ? a_rdata.partner : ai_q;
  assign tgt_in  = (32'(tgt_idx) < ATOM_DEPTH);
  assign ki_in   = (32'(atom_i.kind) < KIND_DEPTH);
  assign kj_in   = (32'(a_rdata.kind) < KIND_DEPTH);

  // coordinate differences, magnitudes fit 24 bits
  assign dxs = {a_rdata.x[23], a_rdata.x} - {atom_i.x[23], atom_i.x};
  assign dys = {a_rdata.y[23], a_rdata.y} - {atom_i.y[23], atom_i.y};
  assign dzs = {a_rdata.z[23], a_rdata.z} - {atom_i.z[23], atom_i.z};

  // sqrt step
  assign sq_rem_sh = {sq_rem, sq_val[29:28]};
  assign sq_trial  = {2'b00, root, 2'b01};
  assign sq_bit    = (sq_rem_sh >= sq_trial);

  // divider step
  assign div_rem_sh  = {div_rem, div_num[63]};
  assign div_den_ext = {1'b0, div_den};
  assign div_bit     = (div_rem_sh >= div_den_ext);
  assign div_rem_new = div_bit ? 57'(div_rem_sh - div_den_ext) : div_rem_sh[56:0];
  assign div_q_next  = {div_q[62:0], div_bit};

  // side 0 updates the first atom with the partner's volume, side 1 the reverse
  assign cur_rad  = side ? kind_j.radius    : kind_i.radius;
  assign cur_th   = side ? kind_j.thickness : kind_i.thickness;
  assign cur_vol  = side ? kind_i.volume    : kind_j.volume;
  assign root_ext = {1'b0, root};
  assign a_dist   = (root_ext >= cur_rad) ? root_ext - cur_rad : cur_rad - root_ext;
  assign aa       = 32'(a_dist) * 32'(a_dist);
  assign tt       = 32'(cur_th) * 32'(cur_th);

  // one exp factor, rounded back to q31
  assign exp_prod = 64'(exp_e) * 64'(EXP_TAB[exp_k]);
  assign exp_rnd  = exp_prod + 64'h4000_0000;

  // saturating accumulate
  assign acc_sum = {1'b0, acc_rdata} + {1'b0, dv};
  assign acc_tgt = side ? pj_q : ai_q;

  // memory port muxing
  always_comb begin
    a_we    = accept && (action == ACT_LOAD_ATOM) && ai_in;
    a_waddr = AW'(atom_index);
    a_wdata = '{x: coord_x, y: coord_y, z: coord_z, kind: class_index,
                hyd: is_hydrogen, partner: partner_index};
    a_re    = 1'b0;
    a_raddr = AW'(atom_index);
    case (state)
      S_IDLE: a_re = accept && ((action == ACT_PAIR) || (action == ACT_READ));
      S_PA: begin
        a_re    = 1'b1;
        a_raddr = AW'(pj_q);
      end
      default: a_re = 1'b0;
    endcase

    k_we    = accept && (action == ACT_LOAD_CLASS) && ci_in;
    k_waddr = KW'(class_index);
    k_wdata = '{radius: radius_value, volume: volume_value, thickness: thickness_value};
    k_re    = 1'b0;
    k_raddr = KW'(atom_i.kind);
    case (state)
      S_PB: k_re = 1'b1;
      S_SQ: begin
        k_re    = 1'b1;
        k_raddr = KW'(kj_idx);
      end
      default: k_re = 1'b0;
    endcase

    acc_we    = 1'b0;
    acc_waddr = AW'(atom_index);
    acc_wdata = '0;
    acc_re    = 1'b0;
    acc_raddr = AW'(acc_tgt);
    case (state)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
      end
      S_IDLE: acc_we = accept && (action == ACT_LOAD_ATOM) && ai_in;
      S_R1: begin
        acc_re    = 1'b1;
        acc_raddr = AW'(tgt_idx);
      end
      S_ACC_RD: acc_re = 1'b1;
      S_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = AW'(acc_tgt);
        acc_wdata = acc_sum[32] ? SAT32 : acc_sum[31:0];
      end
      default: acc_re = 1'b0;
    endcase
  end

  psva_ram #(.WIDTH(ATOM_W), .DEPTH(ATOM_DEPTH), .AW(AW)) u_atom_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  psva_ram #(.WIDTH(KIND_W), .DEPTH(KIND_DEPTH), .AW(KW)) u_kind_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  psva_ram #(.WIDTH(32), .DEPTH(ATOM_DEPTH), .AW(AW)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cutoff    <= 30'd16777216;
      out_valid <= 1'b0;
      side      <= 1'b0;
    end else begin
      if (cutoff_we) begin
        cutoff <= cutoff_squared;
      end
      // result taken by the sink, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_R2)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(ATOM_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end

        S_IDLE: begin
          if (accept) begin
            ai_q    <= atom_index;
            pj_q    <= partner_index;
            read_ok <= ai_in;
            case (action)
              ACT_PAIR: begin
                if (ai_in && pj_in) begin
                  state <= S_PA;
                end
              end
              ACT_READ: state <= S_R1;
              default:  state <= S_IDLE;
            endcase
          end
        end

        // read item: atom record arrives, accumulator read goes out
        S_R1: begin
          tgt_ok <= read_ok && tgt_in;
          state  <= S_R2;
        end

        S_R2: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            read_atom   <= ai_q;
            if (!tgt_ok) begin
              frac_volume <= '0;
            end else if (acc_rdata > 32'(ONE_Q16)) begin
              frac_volume <= ONE_Q16;
            end else begin
              frac_volume <= acc_rdata[16:0];
            end
            state <= S_IDLE;
          end
        end

        // pair item: fetch both atoms and both classes
        S_PA: begin
          atom_i <= a_rdata;
          state  <= S_PB;
        end

        S_PB: begin
          dx     <= dxs[24] ? 24'(-dxs) : dxs[23:0];
          dy     <= dys[24] ? 24'(-dys) : dys[23:0];
          dz     <= dzs[24] ? 24'(-dzs) : dzs[23:0];
          kj_idx <= a_rdata.kind;
          kj_ok  <= kj_in;
          ki_ok  <= ki_in;
          state  <= S_SQ;
        end

        S_SQ: begin
          sq_x   <= 48'(dx) * 48'(dx);
          sq_y   <= 48'(dy) * 48'(dy);
          sq_z   <= 48'(dz) * 48'(dz);
          kind_i <= ki_ok ? k_rdata : '0;
          state  <= S_SUM;
        end

        S_SUM: begin
          r2     <= 50'(sq_x) + 50'(sq_y) + 50'(sq_z);
          kind_j <= kj_ok ? k_rdata : '0;
          state  <= S_CMP;
        end

        S_CMP: begin
          if (r2 > 50'(cutoff)) begin
            state <= S_IDLE;
          end else begin
            sq_val <= r2[29:0];
            sq_rem <= '0;
            root   <= '0;
            sq_cnt <= 4'd14;
            state  <= S_SQRT;
          end
        end

        S_SQRT: begin
          sq_val <= {sq_val[27:0], 2'b00};
          sq_rem <= sq_bit ? 17'(sq_rem_sh - sq_trial) : sq_rem_sh[16:0];
          root   <= {root[13:0], sq_bit};
          if (sq_cnt == 4'd0) begin
            side  <= 1'b0;
            state <= S_SIDE;
          end else begin
            sq_cnt <= sq_cnt - 1'b1;
          end
        end

        // one side of the pair: exponent argument by division
        S_SIDE: begin
          if (cur_th == 16'd0) begin
            dv    <= '0;
            state <= S_ACC_RD;
          end else if (r2 == 50'd0) begin
            dv    <= SAT32;
            state <= S_ACC_RD;
          end else begin
            div_num <= {20'd0, aa, 12'd0};
            div_den <= 57'(tt);
            div_rem <= '0;
            div_q   <= '0;
            div_cnt <= '0;
            state   <= S_XDIV;
          end
        end

        S_XDIV: begin
          div_num <= {div_num[62:0], 1'b0};
          div_rem <= div_rem_new;
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd63) begin
            exp_x <= div_q_next[16:0];
            exp_e <= (|div_q_next[63:17]) ? 32'd0 : 32'h8000_0000;
            exp_k <= '0;
            state <= S_EXP;
          end
        end

        S_EXP: begin
          if (exp_x[exp_k]) begin
            exp_e <= exp_rnd[62:31];
          end
          if (exp_k == 5'(EXP_BITS - 1)) begin
            state <= S_MUL1;
          end else begin
            exp_k <= exp_k + 1'b1;
          end
        end

        S_MUL1: begin
          prod_ve <= 52'(cur_vol) * 52'(exp_e);
          den_v   <= 46'(cur_th) * 46'(r2[29:0]);
          state   <= S_MUL2;
        end

        S_MUL2: begin
          div_num <= 64'(prod_ve[51:16]) * 64'(K_Q32);
          div_den <= {den_v, 11'd0};
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= '0;
          state   <= S_VDIV;
        end

        S_VDIV: begin
          div_num <= {div_num[62:0], 1'b0};
          div_rem <= div_rem_new;
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd63) begin
            dv    <= (|div_q_next[63:32]) ? SAT32 : div_q_next[31:0];
            state <= S_ACC_RD;
          end
        end

        S_ACC_RD: state <= S_ACC_WR;

        S_ACC_WR: begin
          if (!side) begin
            side  <= 1'b1;
            state <= S_SIDE;
          end else begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // divider remainder always stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    ((state == S_XDIV) || (state == S_VDIV)) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  // the clearing sweep runs once, right after reset
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("clearing sweep restarted");

  // exp value never exceeds 1.0 in q31
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP) |-> (exp_e <= 32'h8000_0000))
    else $error("exp value above one");

  // accumulation never decreases an entry
  a_acc_mono: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC_WR) |-> (acc_wdata >= acc_rdata))
    else $error("accumulator wrapped");

  // a fraction is at most 1.0
  a_frac_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frac_volume <= ONE_Q16))
    else $error("fraction above one");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// item-level check of the pair solvation volume accumulator core: a queue-fed
// driver and a result monitor run against an in-bench predictor of the
// per-atom shell accumulation, over several cutoff settings and idle patterns
// ----------------------------------------------------------------------------
module tb;
  import psva_pkg::*;

  typedef struct {
    action_t            act;
    logic [9:0]         ai;
    logic [9:0]         pj;
    logic [7:0]         ci;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               hyd;
    logic [15:0]        rad;
    logic [19:0]        vol;
    logic [15:0]        th;
  } solv_item_t;

  typedef struct {
    logic [9:0]  atom;
    logic [16:0] frac;
  } frac_read_t;

  logic clk, rst;
  logic cutoff_we;
  logic [29:0] cutoff_squared;
  logic in_valid, in_stall;
  logic [1:0] action;
  logic [9:0] atom_index, partner_index;
  logic [7:0] class_index;
  logic signed [23:0] coord_x, coord_y, coord_z;
  logic is_hydrogen;
  logic [15:0] radius_value, thickness_value;
  logic [19:0] volume_value;
  logic out_valid, out_stall;
  logic [9:0] read_atom;
  logic [16:0] frac_volume;

  pair_solvation_volume_accumulator_core i_dut (
    .clk(clk), .rst(rst),
    .cutoff_we(cutoff_we), .cutoff_squared(cutoff_squared),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .atom_index(atom_index), .partner_index(partner_index),
    .class_index(class_index), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .is_hydrogen(is_hydrogen), .radius_value(radius_value),
    .volume_value(volume_value), .thickness_value(thickness_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_atom(read_atom), .frac_volume(frac_volume)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // ---------------------------------------------------------------- predictor
  // shadow copy of the block's atom, class and accumulator memories and the cutoff
  bit signed [23:0] sh_x [1024], sh_y [1024], sh_z [1024];
  bit [7:0]         sh_kind [1024];
  bit               sh_hyd [1024];
  bit [9:0]         sh_bond [1024];
  bit [31:0]        sh_acc [1024];
  bit [15:0]        sh_rad [256], sh_th [256];
  bit [19:0]        sh_vol [256];
  bit [29:0]        sh_cutoff = 30'd16777216;

  solv_item_t item_q[$];     // items waiting for the driver
  frac_read_t frac_q[$];     // fractions expected from accepted reads
  int errors = 0;
  int send_pct = 0, stall_pct = 0;
  logic in_acc;

  // bookkeeping for the stimulus: which entries have been written
  bit atom_done [1024];
  bit kind_done [256];
  int atom_list[$], kind_list[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  // exp(-x/4096) in q31, one squared factor per exponent bit
  function automatic longint unsigned decay_q31(longint unsigned x);
    longint unsigned e, t;
    e = 64'd1 << 31;
    t = 64'd2146959424;
    if (x >= (64'd1 << 17)) return 0;
    for (int k = 0; k < 17; k++) begin
      if (x[k]) e = (e * t + (64'd1 << 30)) >> 31;
      t = (t * t + (64'd1 << 30)) >> 31;
    end
    return e;
  endfunction

  function automatic longint unsigned shell_gain(longint unsigned r2, longint unsigned rad,
                                                 longint unsigned vol, longint unsigned th);
    longint unsigned r, a, x, num, den;
    if (th == 0) return 0;
    if (r2 == 0) return 64'hFFFF_FFFF;
    r = int_sqrt(r2);
    a = (r >= rad) ? r - rad : rad - r;
    x = ((a * a) << 12) / (th * th);
    num = ((vol * decay_q31(x)) >> 16) * 64'd385660408;
    den = (th * r2) << 11;
    num = num / den;
    return (num > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : num;
  endfunction

  function automatic longint unsigned axis_sq(bit signed [23:0] p, bit signed [23:0] q);
    longint d;
    d = longint'(p) - longint'(q);
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  function automatic bit [31:0] sat_add(bit [31:0] acc, longint unsigned dv);
    longint unsigned s;
    s = longint'(acc) + dv;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit [16:0] clamp_frac(bit [31:0] acc);
    return (acc > 32'd65536) ? 17'd65536 : acc[16:0];
  endfunction

  // apply one accepted item to the shadow state, queue a fraction for a read
  task automatic solvation_predict(solv_item_t it);
    longint unsigned r2, dvi, dvj;
    int ka, kb;
    frac_read_t fr;
    case (it.act)
      ACT_LOAD_ATOM: begin
        sh_x[it.ai] = it.x;
        sh_y[it.ai] = it.y;
        sh_z[it.ai] = it.z;
        sh_kind[it.ai] = it.ci;
        sh_hyd[it.ai] = it.hyd;
        sh_bond[it.ai] = it.pj;
        sh_acc[it.ai] = 0;
      end
      ACT_LOAD_CLASS: begin
        sh_rad[it.ci] = it.rad;
        sh_vol[it.ci] = it.vol;
        sh_th[it.ci] = it.th;
      end
      ACT_PAIR: begin
        r2 = axis_sq(sh_x[it.pj], sh_x[it.ai]) + axis_sq(sh_y[it.pj], sh_y[it.ai])
           + axis_sq(sh_z[it.pj], sh_z[it.ai]);
        if (r2 <= longint'(sh_cutoff)) begin
          ka = sh_kind[it.ai];
          kb = sh_kind[it.pj];
          dvi = shell_gain(r2, sh_rad[ka], sh_vol[kb], sh_th[ka]);
          dvj = shell_gain(r2, sh_rad[kb], sh_vol[ka], sh_th[kb]);
          sh_acc[it.ai] = sat_add(sh_acc[it.ai], dvi);
          sh_acc[it.pj] = sat_add(sh_acc[it.pj], dvj);
        end
      end
      ACT_READ: begin
        fr.atom = it.ai;
        // hydrogen takes its bonded atom's value, one link only
        fr.frac = sh_hyd[it.ai] ? clamp_frac(sh_acc[sh_bond[it.ai]])
                                : clamp_frac(sh_acc[it.ai]);
        frac_q.push_back(fr);
      end
    endcase
  endtask

  // ------------------------------------------------------------------- driver
  // new items go out on the falling edge once the last one has been taken
  always @(negedge clk) begin
    solv_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      action <= ACT_LOAD_ATOM;
      atom_index <= '0;
      partner_index <= '0;
      class_index <= '0;
      coord_x <= '0;
      coord_y <= '0;
      coord_z <= '0;
      is_hydrogen <= 1'b0;
      radius_value <= '0;
      volume_value <= '0;
      thickness_value <= 16'd1;
    end else if (!in_valid || in_acc) begin
      if (item_q.size() > 0 && $urandom_range(99) >= send_pct) begin
        it = item_q.pop_front();
        action <= it.act;
        atom_index <= it.ai;
        partner_index <= it.pj;
        class_index <= it.ci;
        coord_x <= it.x;
        coord_y <= it.y;
        coord_z <= it.z;
        is_hydrogen <= it.hyd;
        radius_value <= it.rad;
        volume_value <= it.vol;
        thickness_value <= it.th;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    solv_item_t it;
    frac_read_t fr;
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && !in_stall;
      // input side: feed each accepted item to the predictor
      if (in_valid && !in_stall) begin
        it.act = action_t'(action);
        it.ai = atom_index;
        it.pj = partner_index;
        it.ci = class_index;
        it.x = coord_x;
        it.y = coord_y;
        it.z = coord_z;
        it.hyd = is_hydrogen;
        it.rad = radius_value;
        it.vol = volume_value;
        it.th = thickness_value;
        solvation_predict(it);
      end
      // output side: compare against the oldest expected fraction
      if (out_valid && !out_stall) begin
        if (frac_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: atom %0d frac %0d", read_atom, frac_volume);
        end else begin
          fr = frac_q.pop_front();
          if (fr.atom !== read_atom || fr.frac !== frac_volume) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected atom %0d frac %0d, got atom %0d frac %0d",
                       fr.atom, fr.frac, read_atom, frac_volume);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic solv_item_t noise_item();
    solv_item_t it;
    it.act = action_t'($urandom_range(3));
    it.ai = 10'($urandom);
    it.pj = 10'($urandom);
    it.ci = 8'($urandom);
    it.x = 24'($urandom);
    it.y = 24'($urandom);
    it.z = 24'($urandom);
    it.hyd = 1'($urandom);
    it.rad = 16'($urandom);
    it.vol = 20'($urandom);
    it.th = 16'($urandom_range(65535, 1));
    return it;
  endfunction

  task automatic put_atom(int idx, int kind, int x, int y, int z, bit hyd, int bond);
    solv_item_t it;
    it = noise_item();
    it.act = ACT_LOAD_ATOM;
    it.ai = 10'(idx);
    it.ci = 8'(kind);
    it.x = 24'(x);
    it.y = 24'(y);
    it.z = 24'(z);
    it.hyd = hyd;
    it.pj = 10'(bond);
    if (!atom_done[idx]) atom_list.push_back(idx);
    atom_done[idx] = 1'b1;
    item_q.push_back(it);
  endtask

  task automatic put_class(int kind, int rad, int vol, int th);
    solv_item_t it;
    it = noise_item();
    it.act = ACT_LOAD_CLASS;
    it.ci = 8'(kind);
    it.rad = 16'(rad);
    it.vol = 20'(vol);
    it.th = 16'(th);
    if (!kind_done[kind]) kind_list.push_back(kind);
    kind_done[kind] = 1'b1;
    item_q.push_back(it);
  endtask

  task automatic put_pair(int a, int b);
    solv_item_t it;
    it = noise_item();
    it.act = ACT_PAIR;
    it.ai = 10'(a);
    it.pj = 10'(b);
    item_q.push_back(it);
  endtask

  task automatic put_read(int a);
    solv_item_t it;
    it = noise_item();
    it.act = ACT_READ;
    it.ai = 10'(a);
    item_q.push_back(it);
  endtask

  function automatic int cluster_coord();
    return ($urandom_range(99) < 8) ? int'($signed(24'($urandom)))
                                    : int'($urandom_range(6000)) - 3000;
  endfunction

  // random mix: mostly pairs and reads among a working set of loaded atoms
  task automatic fill_random(int count);
    int roll, a, b;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      a = atom_list[$urandom_range(atom_list.size() - 1)];
      b = atom_list[$urandom_range(atom_list.size() - 1)];
      if (roll < 12) begin
        // mostly reuse the working set, sometimes any index
        if ($urandom_range(3) == 0) a = $urandom_range(1023);
        put_atom(a, kind_list[$urandom_range(kind_list.size() - 1)],
                 cluster_coord(), cluster_coord(), cluster_coord(),
                 ($urandom_range(4) == 0), ($urandom_range(3) == 0) ? $urandom_range(1023) : b);
      end else if (roll < 17) begin
        if ($urandom_range(1)) put_class($urandom_range(255), $urandom_range(65535),
                                         $urandom_range(1048575), $urandom_range(65535, 1));
        else put_class(kind_list[$urandom_range(kind_list.size() - 1)],
                       $urandom_range(2500, 800), $urandom_range(1048575),
                       $urandom_range(2000, 200));
      end else if (roll < 65) begin
        put_pair(a, ($urandom_range(19) == 0) ? a : b);
      end else begin
        put_read(a);
      end
    end
  endtask

  task automatic set_cutoff(int unsigned v);
    @(negedge clk);
    cutoff_we <= 1'b1;
    cutoff_squared <= 30'(v);
    sh_cutoff = 30'(v);
    @(negedge clk);
    cutoff_we <= 1'b0;
  endtask

  // wait until the queue is empty and every fraction is back, then wait out a pair in flight
  task automatic drain();
    while (item_q.size() != 0 || in_valid || frac_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cutoff_we = 1'b0;
    cutoff_squared = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_cutoff(30'd16777216);

    // directed: field extremes, coincident and self pairs, hydrogen links
    put_class(0, 1500, 1048575, 65535);
    put_class(255, 0, 0, 1);
    put_class(7, 65535, 524288, 700);
    put_atom(0, 0, 0, 0, 0, 1'b0, 1023);
    put_atom(1023, 255, 1000, 0, 0, 1'b0, 0);
    put_atom(5, 7, 0, 0, 0, 1'b0, 0);
    put_atom(6, 0, -8388608, -8388608, -8388608, 1'b1, 0);
    put_atom(7, 255, 8388607, 8388607, 8388607, 1'b1, 512);
    put_pair(0, 1023);
    put_pair(1023, 0);
    put_pair(0, 5);           // coincident atoms saturate
    put_pair(0, 0);           // one atom at both ends
    put_pair(6, 7);           // far beyond the cutoff
    put_read(0);
    put_read(1023);
    put_read(5);
    put_read(6);              // hydrogen, bonded atom saturated
    put_read(7);              // hydrogen bonded to a cleared slot
    put_class(1, 1200, 30000, 600);
    put_class(2, 1800, 90000, 900);
    for (int i = 0; i < 40; i++)
      put_atom(100 + i, $urandom_range(2, 1), cluster_coord(), cluster_coord(),
               cluster_coord(), ($urandom_range(4) == 0), 100 + $urandom_range(39));
    drain();

    // random phases with changing cutoff and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_pct = 0;  stall_pct = 0;  set_cutoff(30'd0); end
        1: begin send_pct = 46; stall_pct = 0;  set_cutoff(30'h3FFF_FFFF); end
        2: begin send_pct = 0;  stall_pct = 46; set_cutoff(30'd16777216); end
        default: begin send_pct = 10; stall_pct = 10;
                       set_cutoff($urandom_range(30'd67108864, 30'd4194304)); end
      endcase
      fill_random(355);
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
